@@ sv/qvt_pkg.sv @@
// Shared types and constants for the quorum vote tally table.
// Depends on nothing; the top level and stage modules use it by scoped names.
package qvt_pkg;

  localparam logic [1:0] MODE_OPEN = 2'd0;
  localparam logic [1:0] MODE_YES  = 2'd1;
  localparam logic [1:0] MODE_NO   = 2'd2;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] node_index;
    logic [7:0] commit_quorum;
    logic [7:0] abort_quorum;
  } req_t;

  typedef struct packed {
    logic [3:0]  node_echo;
    logic        restart_node;
    logic        abort_vote;
    logic [15:0] assigned_vote_id;
    logic [7:0]  active_votes;
  } res_t;

  typedef struct packed {
    logic hold_valid;
    logic advance;
  } stage_ctl_t;

endpackage

@@ sv/qvt_if.sv @@
// Request and result channel interfaces for the quorum vote tally table.
// Standalone; no package dependency.
interface qvt_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [3:0] node_index;
  logic [7:0] commit_quorum;
  logic [7:0] abort_quorum;

  modport source (output valid, output mode, output node_index,
                  output commit_quorum, output abort_quorum, input ready);
  modport sink (input valid, input mode, input node_index,
                input commit_quorum, input abort_quorum, output ready);
endinterface

interface qvt_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  node_echo;
  logic        restart_node;
  logic        abort_vote;
  logic [15:0] assigned_vote_id;
  logic [7:0]  active_votes;

  modport source (output valid, output node_echo, output restart_node,
                  output abort_vote, output assigned_vote_id,
                  output active_votes, input ready);
  modport sink (input valid, input node_echo, input restart_node,
                input abort_vote, input assigned_vote_id,
                input active_votes, output ready);
endinterface

@@ sv/quorum_vote_tally_table.sv @@
// Top level of the quorum vote tally table.
// Depends on qvt_pkg, qvt_if, qvt_in_stage, qvt_tally and qvt_out_stage.
//
// The req channel carries one vote word: an open, a yes or a no on a node.
// The rsp channel returns exactly one result word for each request word, in
// order: the node echoed, the restart and abort flags, the record id after
// the word and the number of open votes after the word.
// A request word taken at a clock edge waits in the input register; the record
// table is read from it and updated, and its result lands in the result
// register, at the edge where the result register can take a word.
// One word is taken every cycle while the receiver takes results; the record
// table's read-modify-write completes at each advancing edge and needs no forwarding.
// Reset clears every record, the id counter, the open count and both stage
// valid flags; the block takes words from the first cycle after reset.
// When the receiver stalls, the result register holds its word, the input
// register holds one more word, and req.ready then drops until rsp moves.
module quorum_vote_tally_table #(
  parameter int NODE_COUNT = 16
) (
  input logic      clk,
  input logic      rst,
  qvt_req_if.sink  req,
  qvt_rsp_if.source rsp
);

  qvt_pkg::req_t       in_data;
  qvt_pkg::req_t       hold;
  qvt_pkg::res_t       res;
  qvt_pkg::res_t       out_data;
  qvt_pkg::stage_ctl_t ctl;
  logic                can_load;

  assign in_data.mode          = req.mode;
  assign in_data.node_index    = req.node_index;
  assign in_data.commit_quorum = req.commit_quorum;
  assign in_data.abort_quorum  = req.abort_quorum;

  qvt_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_data  (in_data),
    .in_ready (req.ready),
    .can_load (can_load),
    .ctl      (ctl),
    .hold     (hold)
  );

  qvt_tally #(.NODE_COUNT(NODE_COUNT)) u_tally (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .req (hold),
    .res (res)
  );

  qvt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .res       (res),
    .can_load  (can_load),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (out_data)
  );

  assign rsp.node_echo        = out_data.node_echo;
  assign rsp.restart_node     = out_data.restart_node;
  assign rsp.abort_vote       = out_data.abort_vote;
  assign rsp.assigned_vote_id = out_data.assigned_vote_id;
  assign rsp.active_votes     = out_data.active_votes;

endmodule

@@ sv/qvt_in_stage.sv @@
// Input register of the quorum vote tally table.
// Depends on qvt_pkg for the request word type and stage control struct.
module qvt_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  qvt_pkg::req_t     in_data,
  output logic              in_ready,
  input  logic              can_load,
  output qvt_pkg::stage_ctl_t ctl,
  output qvt_pkg::req_t     hold
);

  logic hold_valid;

  assign ctl.hold_valid = hold_valid;
  assign ctl.advance    = hold_valid && can_load;
  assign in_ready       = !hold_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold <= in_data;
    end
  end

endmodule

@@ sv/qvt_tally.sv @@
// Vote record table and the per-word update and quorum check.
// Depends on qvt_pkg for the request, result and stage control types.
module qvt_tally #(
  parameter int NODE_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  qvt_pkg::stage_ctl_t ctl,
  input  qvt_pkg::req_t       req,
  output qvt_pkg::res_t       res
);

  localparam int DEPTH = (NODE_COUNT < 16) ? NODE_COUNT : 16;
  localparam int IDX_W = $clog2(DEPTH);

  logic [15:0] record_id   [DEPTH];
  logic [7:0]  yes_count   [DEPTH];
  logic [7:0]  no_count    [DEPTH];
  logic [7:0]  commit_need [DEPTH];
  logic [7:0]  abort_need  [DEPTH];
  logic [15:0] id_counter;
  logic [7:0]  open_count;

  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic             do_open;
  logic             do_yes;
  logic             do_no;
  logic [7:0]       yes_inc;
  logic [7:0]       no_inc;
  logic             fire_yes;
  logic             fire_no;
  logic             do_close;
  logic [15:0]      id_counter_next;
  logic [7:0]       open_count_next;
  logic             wr;

  assign idx      = req.node_index[IDX_W-1:0];
  assign in_range = int'(req.node_index) < NODE_COUNT;
  assign wr       = ctl.advance && in_range;

  always_comb begin
    do_open = 1'b0;
    do_yes  = 1'b0;
    do_no   = 1'b0;
    case (req.mode)
      qvt_pkg::MODE_OPEN: do_open = in_range;
      qvt_pkg::MODE_YES:  do_yes  = in_range && (yes_count[idx] != qvt_pkg::COUNT_MAX);
      qvt_pkg::MODE_NO:   do_no   = in_range && (no_count[idx] != qvt_pkg::COUNT_MAX);
      default: ;
    endcase
  end

  assign yes_inc         = yes_count[idx] + 8'd1;
  assign no_inc          = no_count[idx] + 8'd1;
  assign fire_yes        = do_yes && (yes_inc == commit_need[idx]);
  assign fire_no         = do_no && (no_inc == abort_need[idx]);
  assign do_close        = fire_yes || fire_no;
  assign id_counter_next = id_counter + 16'd1;

  always_comb begin
    open_count_next = open_count;
    if (do_open && open_count != qvt_pkg::COUNT_MAX) begin
      open_count_next = open_count + 8'd1;
    end else if (do_close && open_count != 8'd0) begin
      open_count_next = open_count - 8'd1;
    end
  end

  always_comb begin
    res.node_echo    = req.node_index;
    res.restart_node = fire_yes;
    res.abort_vote   = fire_no;
    res.active_votes = open_count_next;
    if (!in_range || do_close) begin
      res.assigned_vote_id = 16'd0;
    end else if (do_open) begin
      res.assigned_vote_id = id_counter_next;
    end else begin
      res.assigned_vote_id = record_id[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_counter <= 16'd0;
      open_count <= 8'd0;
      for (int i = 0; i < DEPTH; i++) begin
        record_id[i]   <= 16'd0;
        yes_count[i]   <= 8'd0;
        no_count[i]    <= 8'd0;
        commit_need[i] <= 8'd0;
        abort_need[i]  <= 8'd0;
      end
    end else if (wr) begin
      open_count <= open_count_next;
      if (do_open) begin
        id_counter       <= id_counter_next;
        record_id[idx]   <= id_counter_next;
        yes_count[idx]   <= 8'd0;
        no_count[idx]    <= 8'd0;
        commit_need[idx] <= req.commit_quorum;
        abort_need[idx]  <= req.abort_quorum;
      end
      if (do_yes) begin
        yes_count[idx] <= yes_inc;
      end
      if (do_no) begin
        no_count[idx] <= no_inc;
      end
      if (do_close) begin
        record_id[idx] <= 16'd0;
      end
    end
  end

endmodule

@@ sv/qvt_out_stage.sv @@
// Result register of the quorum vote tally table.
// Depends on qvt_pkg for the result word type and stage control struct.
module qvt_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  qvt_pkg::stage_ctl_t ctl,
  input  qvt_pkg::res_t       res,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output qvt_pkg::res_t       out_data
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= ctl.advance;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      out_data <= res;
    end
  end

endmodule

@@ sv/qvt_checker.sv @@
// Port-level checks for the quorum vote tally table, bound to the top level.
// Depends on quorum_vote_tally_table and its channel interfaces.
module qvt_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        restart_node,
  input logic        abort_vote,
  input logic [15:0] assigned_vote_id,
  input logic [7:0]  active_votes
);

  // A result word cannot appear in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result word valid right after reset");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(restart_node && abort_vote))
    else $error("restart and abort flagged together");

  // A vote that reaches its quorum closes the record.
  a_close_clears_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (restart_node || abort_vote) |-> assigned_vote_id == 16'd0)
    else $error("closed record still shows an id");

  // With a full result register stalled, the input side can hold one word only.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready && req_valid && req_ready |=> !req_ready || rsp_ready)
    else $error("input accepted beyond the two stage registers");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(active_votes))
    else $error("stalled result word changed");

endmodule

bind quorum_vote_tally_table qvt_checker u_qvt_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .restart_node     (rsp.restart_node),
  .abort_vote       (rsp.abort_vote),
  .assigned_vote_id (rsp.assigned_vote_id),
  .active_votes     (rsp.active_votes)
);
